@@ design/lbs_pkg.sv @@
// Shared constants, codes, types and saturation helpers for the skinning core.
`default_nettype none
package lbs_pkg;

    localparam int WORDS_PER_BONE   = 12;
    localparam int SLOTS            = 4;
    localparam int MAX_BONES_DEF    = 64;
    localparam int BPV_DEF          = 4;
    localparam int FIFO_DEPTH       = 8;
    localparam int FIFO_AW          = $clog2(FIFO_DEPTH);
    localparam int CREDIT_W         = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_POINT = 2'd1,
        ACT_DIR   = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // one bone matrix, row major, word 3/7/11 is translation
    typedef logic [WORDS_PER_BONE-1:0][31:0] t_row;

    typedef struct packed {
        logic               is_point;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
    } t_side;

    typedef struct packed {
        logic        valid;
        logic        first;
        logic        last;
        logic        zero;
        logic [15:0] weight;
        t_side       side;
    } t_blend_req;

    typedef struct packed {
        logic  valid;
        logic  flag;
        t_row  blend;
        t_side side;
    } t_mat;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               sat;
    } t_res;

    // clamp to 32-bit signed; bit 32 of the result is the clamp flag
    function automatic logic [32:0] sat_blend(input logic signed [35:0] v);
        logic [32:0] r;
        if (v > 36'sh0_7FFF_FFFF) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -36'sh0_8000_0000) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    function automatic logic [32:0] sat_out(input logic signed [49:0] v);
        logic [32:0] r;
        if (v > 50'sh0_0000_7FFF_FFFF) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -50'sh0_0000_8000_0000) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ design/lbs_in_if.sv @@
// Input channel: valid/ready handshake with one skin or load item per beat.
`default_nettype none
interface lbs_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [5:0]         bone_0;
    logic [5:0]         bone_1;
    logic [5:0]         bone_2;
    logic [5:0]         bone_3;
    logic [15:0]        weight_0;
    logic [15:0]        weight_1;
    logic [15:0]        weight_2;
    logic [15:0]        weight_3;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;

    modport source (
        output valid, action, bone_0, bone_1, bone_2, bone_3,
               weight_0, weight_1, weight_2, weight_3, coord_x, coord_y, coord_z,
        input  ready
    );
    modport sink (
        input  valid, action, bone_0, bone_1, bone_2, bone_3,
               weight_0, weight_1, weight_2, weight_3, coord_x, coord_y, coord_z,
        output ready
    );
endinterface
`default_nettype wire

@@ design/lbs_out_if.sv @@
// Output channel: valid/ready handshake with one transformed vector per beat.
`default_nettype none
interface lbs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;

    modport source (output valid, out_x, out_y, out_z, saturated, input ready);
    modport sink   (input  valid, out_x, out_y, out_z, saturated, output ready);
endinterface
`default_nettype wire

@@ design/lbs_bone_store.sv @@
// Bone matrix memory: word writes, one whole-bone row read per cycle.
`default_nettype none
module lbs_bone_store #(
    parameter int MAX_BONES = lbs_pkg::MAX_BONES_DEF,
    parameter int BW        = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [BW-1:0] i_wr_bone,
    input  wire logic [3:0]    i_wr_word,
    input  wire logic [31:0]   i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [BW-1:0] i_rd_bone,
    output lbs_pkg::t_row      o_rd_row
);
    import lbs_pkg::*;

    // one entry per bone; a load writes a single word lane of its entry
    t_row mem [MAX_BONES];
    t_row r_row;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_bone][i_wr_word] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_row <= mem[i_rd_bone];
        end
    end

    assign o_rd_row = r_row;
endmodule
`default_nettype wire

@@ design/lbs_blend.sv @@
// Blend stages: weight products, per-bone accumulation, saturation.
`default_nettype none
module lbs_blend (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  lbs_pkg::t_blend_req i_req,
    input  lbs_pkg::t_row      i_row,
    output lbs_pkg::t_mat      o_mat
);
    import lbs_pkg::*;

    logic               r2_valid, r2_first, r2_last;
    t_side              r2_side;
    logic signed [33:0] r2_prod [WORDS_PER_BONE];
    logic               r3_valid;
    t_side              r3_side;
    logic signed [35:0] r3_acc [WORDS_PER_BONE];
    t_mat               r4_mat;
    logic signed [48:0] n_full [WORDS_PER_BONE];
    logic [32:0]        n_sat  [WORDS_PER_BONE];
    logic               n_flag;

    always_comb begin
        n_flag = 1'b0;
        for (int e = 0; e < WORDS_PER_BONE; e++) begin
            n_full[e] = $signed(i_row[e]) * $signed({1'b0, i_req.weight});
            n_sat[e]  = sat_blend(r3_acc[e]);
            n_flag    = n_flag | n_sat[e][32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid     <= 1'b0;
            r3_valid     <= 1'b0;
            r4_mat.valid <= 1'b0;
        end else begin
            r2_valid     <= i_req.valid;
            r3_valid     <= r2_valid && r2_last;
            r4_mat.valid <= r3_valid;
        end
        // drop the product of an out-of-range bone
        r2_first <= i_req.first;
        r2_last  <= i_req.last;
        r2_side  <= i_req.side;
        for (int e = 0; e < WORDS_PER_BONE; e++) begin
            r2_prod[e] <= i_req.zero ? 34'sd0 : n_full[e][48:15];
        end
        if (r2_valid) begin
            for (int e = 0; e < WORDS_PER_BONE; e++) begin
                r3_acc[e] <= r2_first ? 36'(r2_prod[e]) : r3_acc[e] + 36'(r2_prod[e]);
            end
            if (r2_last) begin
                r3_side <= r2_side;
            end
        end
        if (r3_valid) begin
            r4_mat.side <= r3_side;
            r4_mat.flag <= n_flag;
            for (int e = 0; e < WORDS_PER_BONE; e++) begin
                r4_mat.blend[e] <= n_sat[e][31:0];
            end
        end
    end

    assign o_mat = r4_mat;
endmodule
`default_nettype wire

@@ design/lbs_xform.sv @@
// Transform stages: blended matrix times vector, translation, saturation.
`default_nettype none
module lbs_xform (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  lbs_pkg::t_mat i_mat,
    output lbs_pkg::t_res o_res
);
    import lbs_pkg::*;

    logic               r5_valid, r5_flag;
    logic signed [47:0] r5_prod [3][3];
    logic signed [31:0] r5_trans [3];
    t_res               r6_res;
    logic signed [63:0] n_full [3][3];
    logic signed [31:0] n_vec [3];
    logic signed [49:0] n_sum [3];
    logic [32:0]        n_sat [3];

    always_comb begin
        n_vec[0] = i_mat.side.vx;
        n_vec[1] = i_mat.side.vy;
        n_vec[2] = i_mat.side.vz;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_full[r][c] = $signed(i_mat.blend[r*4+c]) * n_vec[c];
            end
            n_sum[r] = 50'(r5_prod[r][0]) + 50'(r5_prod[r][1]) + 50'(r5_prod[r][2])
                     + 50'(r5_trans[r]);
            n_sat[r] = sat_out(n_sum[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid     <= 1'b0;
            r6_res.valid <= 1'b0;
        end else begin
            r5_valid     <= i_mat.valid;
            r6_res.valid <= r5_valid;
        end
        r5_flag <= i_mat.flag;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r5_prod[r][c] <= n_full[r][c][63:16];
            end
            // a direction drops the translation column
            r5_trans[r] <= i_mat.side.is_point ? $signed(i_mat.blend[r*4+3]) : 32'sd0;
        end
        r6_res.x   <= n_sat[0][31:0];
        r6_res.y   <= n_sat[1][31:0];
        r6_res.z   <= n_sat[2][31:0];
        r6_res.sat <= r5_flag | n_sat[0][32] | n_sat[1][32] | n_sat[2][32];
    end

    assign o_res = r6_res;
endmodule
`default_nettype wire

@@ design/lbs_out_fifo.sv @@
// Result queue that absorbs the pipeline while the receiver stalls.
`default_nettype none
module lbs_out_fifo (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  lbs_pkg::t_res i_res,
    input  wire logic     i_pop,
    output logic          o_valid,
    output lbs_pkg::t_res o_head
);
    import lbs_pkg::*;

    t_res                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, r_rd;
    logic [CREDIT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_res.valid) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + CREDIT_W'(i_res.valid) - CREDIT_W'(i_pop);
        end
        if (i_res.valid) begin
            r_mem[r_wr] <= i_res;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
endmodule
`default_nettype wire

@@ design/linear_blend_skinning_core.sv @@
// Top level of the four-bone linear blend skinning core.
//
// Channels: i_in takes one item per beat. A load item (action 0) writes one
// 32-bit word of a bone matrix (bone_0 = slot, bone_1 = word 0..11, coord_x
// = value) and gives no result. A skin item (1 = point, 2 = direction)
// blends up to four bone matrices by their Q1.15 weights and transforms the
// Q16.16 vector; its result leaves on o_out, in order, one beat per item.
// Throughput: a skin item holds the bone sequencer for one bone row read per
// bone, min(4, BONES_PER_VERTEX) rows, one row per cycle from the read port
// of the bone store; a load needs no read. The next item can be taken in the
// last read cycle of the current. A result passes the row read, the sideband
// register, the blend stages and the transform stages into the result queue.
// Reset clears the sequencer, the pipeline valid bits and the result queue; the
// bone store is not cleared and must be written before it is read.
// When the receiver stalls, results collect in an eight-entry queue; input
// is not ready while eight skin results are outstanding.
`default_nettype none
module linear_blend_skinning_core #(
    parameter int MAX_BONES        = lbs_pkg::MAX_BONES_DEF,
    parameter int BONES_PER_VERTEX = lbs_pkg::BPV_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lbs_in_if.sink    i_in,
    lbs_out_if.source o_out
);
    import lbs_pkg::*;

    localparam int BW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam int NB = (BONES_PER_VERTEX < SLOTS) ? BONES_PER_VERTEX : SLOTS;

    // sequencer state
    logic                r_busy;
    logic [1:0]          r_k;
    logic [5:0]          r_bone [SLOTS];
    logic [15:0]         r_weight [SLOTS];
    t_side               r_side;
    logic [CREDIT_W-1:0] r_credit;
    t_blend_req          r1_req;

    logic       seq_last, accept, is_skin, pop, wr_en, rd_in_range;
    logic [7:0] wr_pad, rd_pad;
    t_row       rd_row;
    t_mat       mat;
    t_res       res, head;

    assign seq_last = r_busy && (r_k == 2'(NB - 1));
    // take a new item in the last read cycle so back-to-back items keep the sequencer busy
    assign i_in.ready = (!r_busy || seq_last) && (r_credit < CREDIT_W'(FIFO_DEPTH));
    assign accept   = i_in.valid && i_in.ready;
    assign is_skin  = (i_in.action == ACT_POINT) || (i_in.action == ACT_DIR);
    assign pop      = o_out.valid && o_out.ready;

    // load: write straight into the store; ignore a bad slot or word
    assign wr_pad = {2'b00, i_in.bone_0};
    assign wr_en  = accept && (i_in.action == ACT_LOAD)
                 && ({1'b0, wr_pad} < 9'(MAX_BONES))
                 && (i_in.bone_1 < 6'(WORDS_PER_BONE));

    assign rd_pad      = {2'b00, r_bone[r_k]};
    assign rd_in_range = {1'b0, rd_pad} < 9'(MAX_BONES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_k          <= '0;
            r_credit     <= '0;
            r1_req.valid <= 1'b0;
        end else begin
            if (accept && is_skin) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (seq_last) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_k <= r_k + 1'b1;
            end
            r_credit     <= r_credit + CREDIT_W'(accept && is_skin) - CREDIT_W'(pop);
            r1_req.valid <= r_busy;
        end
        if (accept && is_skin) begin
            r_bone[0]       <= i_in.bone_0;
            r_bone[1]       <= i_in.bone_1;
            r_bone[2]       <= i_in.bone_2;
            r_bone[3]       <= i_in.bone_3;
            r_weight[0]     <= i_in.weight_0;
            r_weight[1]     <= i_in.weight_1;
            r_weight[2]     <= i_in.weight_2;
            r_weight[3]     <= i_in.weight_3;
            r_side.is_point <= (i_in.action == ACT_POINT);
            r_side.vx       <= i_in.coord_x;
            r_side.vy       <= i_in.coord_y;
            r_side.vz       <= i_in.coord_z;
        end
        // align sideband with the registered row read
        r1_req.first  <= (r_k == 2'd0);
        r1_req.last   <= seq_last;
        r1_req.zero   <= !rd_in_range;
        r1_req.weight <= r_weight[r_k];
        r1_req.side   <= r_side;
    end

    lbs_bone_store #(.MAX_BONES(MAX_BONES), .BW(BW)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_bone (wr_pad[BW-1:0]),
        .i_wr_word (i_in.bone_1[3:0]),
        .i_wr_data (i_in.coord_x),
        .i_rd_en   (r_busy),
        .i_rd_bone (rd_pad[BW-1:0]),
        .o_rd_row  (rd_row)
    );

    lbs_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r1_req),
        .i_row   (rd_row),
        .o_mat   (mat)
    );

    lbs_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (mat),
        .o_res   (res)
    );

    lbs_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .i_pop   (pop),
        .o_valid (o_out.valid),
        .o_head  (head)
    );

    assign o_out.out_x     = head.x;
    assign o_out.out_y     = head.y;
    assign o_out.out_z     = head.z;
    assign o_out.saturated = head.sat;

    // outstanding results never exceed the queue depth
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CREDIT_W'(FIFO_DEPTH))
        else $error("credit count above queue depth");

    // a result beat needs an outstanding skin item
    a_out_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_credit != '0))
        else $error("result without outstanding item");

    // the sequencer keeps reading until the last bone
    a_seq_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !seq_last) |=> r_busy)
        else $error("sequencer dropped an item mid-read");

    // no item is taken while bone reads remain
    a_no_early_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !seq_last) |-> !i_in.ready)
        else $error("input ready during bone reads");
endmodule
`default_nettype wire
